>>> rtl/mbc_pkg.sv
// ----------------------------------------------------------------------------
// mbc_pkg
// Shared types and constants of the maze backtracker carver: direction codes,
// register indexes, the controller/datapath command and status words.
// ----------------------------------------------------------------------------
package mbc_pkg;

    localparam logic [2:0] DIR_NONE  = 3'd0;
    localparam logic [2:0] DIR_UP    = 3'd1;
    localparam logic [2:0] DIR_LEFT  = 3'd2;
    localparam logic [2:0] DIR_DOWN  = 3'd3;
    localparam logic [2:0] DIR_RIGHT = 3'd4;

    localparam logic CFG_GRID_WIDTH  = 1'b0;
    localparam logic CFG_GRID_HEIGHT = 1'b1;

    // candidate slots, in listing order
    localparam logic [1:0] NB_RIGHT = 2'd0;
    localparam logic [1:0] NB_DOWN  = 2'd1;
    localparam logic [1:0] NB_LEFT  = 2'd2;
    localparam logic [1:0] NB_UP    = 2'd3;

    typedef enum logic [2:0] {
        EMIT_NONE = 3'd0,
        EMIT_FIN  = 3'd1,
        EMIT_ZERO = 3'd2,
        EMIT_POP  = 3'd3,
        EMIT_STEP = 3'd4
    } t_emit;

    typedef struct packed {
        logic       load_rv;
        logic       clr_step;
        logic       rd_top;
        logic       nbr_rd;
        logic [1:0] rd_idx;
        logic       head_wr;
        logic       col_en;
        logic [1:0] col_idx;
        logic       choose;
        logic       pop;
        logic       wall_wr;
        logic       node_wr;
        t_emit      emit;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic clr_last;
        logic none;
    } t_stat;

    function automatic logic [1:0] mod3_16(input logic [15:0] v);
        logic [4:0] s;
        logic [2:0] t;
        logic [1:0] r;
        s = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6])
          + 5'(v[9:8]) + 5'(v[11:10]) + 5'(v[13:12]) + 5'(v[15:14]);
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        unique case (t)
            3'd0, 3'd3, 3'd6: r = 2'd0;
            3'd1, 3'd4, 3'd7: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] slot_dir(input logic [1:0] idx);
        logic [2:0] d;
        unique case (idx)
            NB_RIGHT: d = DIR_RIGHT;
            NB_DOWN:  d = DIR_DOWN;
            NB_LEFT:  d = DIR_LEFT;
            default:  d = DIR_UP;
        endcase
        return d;
    endfunction

    // pick entry (rv mod count) of the walled candidates, in slot order
    function automatic logic [2:0] pick_dir(input logic [3:0] c, input logic [15:0] rv);
        logic [2:0] n;
        logic [1:0] sel;
        logic [2:0] seen;
        logic [2:0] d;
        n    = 3'($countones(c));
        seen = 3'd0;
        d    = DIR_NONE;
        unique case (n)
            3'd1:    sel = 2'd0;
            3'd2:    sel = {1'b0, rv[0]};
            3'd3:    sel = mod3_16(rv);
            default: sel = rv[1:0];
        endcase
        for (int i = 0; i < 4; i++) begin
            if (c[i]) begin
                if (seen == {1'b0, sel}) begin
                    d = slot_dir(2'(i));
                end
                seen = seen + 3'd1;
            end
        end
        return d;
    endfunction

endpackage

>>> rtl/maze_backtracker_carver_top.sv
// ----------------------------------------------------------------------------
// maze_backtracker_carver_top
// Depth-first maze carver with an explicit node stack.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: raise start with i_action / i_random_value; the word is
//   taken on a rising edge with start high and busy low. i_action 0 makes one
//   carving step, 1 restarts with a fresh, fully walled grid.
//   Result channel: one word per command, held for exactly one cycle with
//   o_result_valid high; the receiver cannot stall it.
//   Config: i_cfg_we with i_cfg_idx 0 (grid width) or 1 (grid height), write
//   only while busy is low.
// Sequence, counted from the accepting edge:
//   Carving step: busy through stack read, four map reads, last compare,
//   choose, wall and node writes, result in the cycle after. Backtrack:
//   busy through the stack read, map reads, last compare and choose.
//   Step on empty stack: result in the cycle right after the accepting edge,
//   no busy time, so one word per cycle.
//   Restart and reset: clearing pass over all 4**clog2(MAX_SIDE) map bits
//   (16384 by default), one bit per cycle; restart ends with a result,
//   reset does not. One map read per cycle sets the step length.
// ----------------------------------------------------------------------------
module maze_backtracker_carver_top #(
    parameter int MAX_SIDE    = 128,
    parameter int STACK_DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_action,
    input  logic [15:0] i_random_value,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    output logic        o_result_valid,
    output logic [6:0]  o_node_x,
    output logic [6:0]  o_node_y,
    output logic [2:0]  o_direction,
    output logic        o_finished
);

    mbc_pkg::t_cmd  cmd;
    mbc_pkg::t_stat stat;

    mbc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    mbc_datapath #(
        .MAX_SIDE    (MAX_SIDE),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_random_value (i_random_value),
        .o_valid        (o_result_valid),
        .o_node_x       (o_node_x),
        .o_node_y       (o_node_y),
        .o_direction    (o_direction),
        .o_finished     (o_finished)
    );

endmodule

>>> rtl/mbc_ctrl.sv
// ----------------------------------------------------------------------------
// mbc_ctrl
// Sequencer of the carver: clearing pass, stack top read, four neighbor reads,
// choice, wall and node writes, result strobes.
// ----------------------------------------------------------------------------
module mbc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_action,
    input  mbc_pkg::t_stat i_stat,
    output mbc_pkg::t_cmd  o_cmd,
    output logic          o_busy
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CLR    = 8'b0000_0010,
        S_TOP    = 8'b0000_0100,
        S_NBR    = 8'b0000_1000,
        S_LAST   = 8'b0001_0000,
        S_CHOOSE = 8'b0010_0000,
        S_WALL   = 8'b0100_0000,
        S_NODE   = 8'b1000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_nbr, n_nbr;
    logic       r_report, n_report;
    logic       accept;

    assign o_busy = (r_state != S_IDLE);
    assign accept = i_start && !o_busy;

    always_comb begin
        n_state  = r_state;
        n_nbr    = r_nbr;
        n_report = r_report;
        o_cmd    = '0;
        o_cmd.emit = mbc_pkg::EMIT_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load_rv = 1'b1;
                    if (i_action) begin
                        n_report = 1'b1;
                        n_state  = S_CLR;
                    end else if (i_stat.empty) begin
                        o_cmd.emit = mbc_pkg::EMIT_FIN;
                    end else begin
                        n_state = S_TOP;
                    end
                end
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                    if (r_report) begin
                        o_cmd.emit = mbc_pkg::EMIT_ZERO;
                    end
                    n_report = 1'b0;
                end
            end
            S_TOP: begin
                o_cmd.rd_top = 1'b1;
                n_nbr   = 2'd0;
                n_state = S_NBR;
            end
            S_NBR: begin
                o_cmd.nbr_rd  = 1'b1;
                o_cmd.rd_idx  = r_nbr;
                o_cmd.head_wr = (r_nbr == 2'd0);
                o_cmd.col_en  = (r_nbr != 2'd0);
                o_cmd.col_idx = r_nbr - 2'd1;
                n_nbr = r_nbr + 2'd1;
                if (r_nbr == 2'd3) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                o_cmd.col_en  = 1'b1;
                o_cmd.col_idx = 2'd3;
                n_state = S_CHOOSE;
            end
            S_CHOOSE: begin
                o_cmd.choose = 1'b1;
                if (i_stat.none) begin
                    o_cmd.pop  = 1'b1;
                    o_cmd.emit = mbc_pkg::EMIT_POP;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_WALL;
                end
            end
            S_WALL: begin
                o_cmd.wall_wr = 1'b1;
                n_state = S_NODE;
            end
            S_NODE: begin
                o_cmd.node_wr = 1'b1;
                o_cmd.emit    = mbc_pkg::EMIT_STEP;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_nbr    <= 2'd0;
            r_report <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_nbr    <= n_nbr;
            r_report <= n_report;
        end
    end

`ifndef NO_ASSERTIONS
    // a step on an empty stack answers at once and starts no work
    a_empty_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_action && i_stat.empty) |=> (r_state == S_IDLE))
        else $error("step on empty stack left idle");
`endif

endmodule

>>> rtl/mbc_datapath.sv
// ----------------------------------------------------------------------------
// mbc_datapath
// Open map and node stack memories, grid size registers, head and candidate
// registers, neighbor choice and the result word register.
// ----------------------------------------------------------------------------
module mbc_datapath #(
    parameter int MAX_SIDE    = 128,
    parameter int STACK_DEPTH = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mbc_pkg::t_cmd  i_cmd,
    output mbc_pkg::t_stat o_stat,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [7:0]     i_cfg_data,
    input  logic [15:0]    i_random_value,
    output logic           o_valid,
    output logic [6:0]     o_node_x,
    output logic [6:0]     o_node_y,
    output logic [2:0]     o_direction,
    output logic           o_finished
);

    localparam int CW    = $clog2(MAX_SIDE);
    localparam int MW    = 2 * CW;
    localparam int MAP_N = 1 << MW;
    localparam int SAW   = $clog2(STACK_DEPTH);
    localparam int CNW   = $clog2(STACK_DEPTH + 1);
    localparam int VW    = (CW + 2 > 8) ? CW + 2 : 8;

    logic            map_mem [MAP_N];
    logic [MW-1:0]   stk_mem [STACK_DEPTH];

    logic [7:0]      r_gw, r_gh;
    logic [CNW-1:0]  r_count;
    logic [MW-1:0]   r_clr_addr;
    logic [15:0]     r_rv;
    logic [MW-1:0]   r_top;
    logic            r_map_q;
    logic [3:0]      r_walled;
    logic [2:0]      r_dir;
    logic            r_valid;
    logic [6:0]      r_x, r_y;
    logic [2:0]      r_odir;
    logic            r_fin;

    logic [CW-1:0]   hx, hy;
    logic [VW-1:0]   wc, hc, w_ext, h_ext, x_ext, y_ext;
    logic [3:0]      inb;
    logic [MW-1:0]   rd_addr, wall_addr, node_addr, map_waddr;
    logic            map_we, map_wd;
    logic            stk_we;
    logic [SAW-1:0]  stk_waddr, stk_raddr;
    logic [MW-1:0]   stk_wd;
    logic            can_push;

    function automatic logic [6:0] to7(input logic [CW-1:0] v);
        logic [15:0] t;
        t = 16'(v);
        return t[6:0];
    endfunction

    assign hx = r_top[CW-1:0];
    assign hy = r_top[MW-1:CW];

    assign w_ext = VW'(r_gw);
    assign h_ext = VW'(r_gh);
    assign wc = (w_ext == '0) ? VW'(1) : (w_ext > VW'(MAX_SIDE)) ? VW'(MAX_SIDE) : w_ext;
    assign hc = (h_ext == '0) ? VW'(1) : (h_ext > VW'(MAX_SIDE)) ? VW'(MAX_SIDE) : h_ext;
    assign x_ext = VW'(hx);
    assign y_ext = VW'(hy);

    assign inb[mbc_pkg::NB_RIGHT] = (x_ext + VW'(2)) < wc;
    assign inb[mbc_pkg::NB_DOWN]  = (y_ext + VW'(2)) < hc;
    assign inb[mbc_pkg::NB_LEFT]  = x_ext >= VW'(2);
    assign inb[mbc_pkg::NB_UP]    = y_ext >= VW'(2);

    always_comb begin
        unique case (i_cmd.rd_idx)
            mbc_pkg::NB_RIGHT: rd_addr = {hy, hx + CW'(2)};
            mbc_pkg::NB_DOWN:  rd_addr = {hy + CW'(2), hx};
            mbc_pkg::NB_LEFT:  rd_addr = {hy, hx - CW'(2)};
            default:           rd_addr = {hy - CW'(2), hx};
        endcase
    end

    always_comb begin
        unique case (r_dir)
            mbc_pkg::DIR_RIGHT: begin
                wall_addr = {hy, hx + CW'(1)};
                node_addr = {hy, hx + CW'(2)};
            end
            mbc_pkg::DIR_DOWN: begin
                wall_addr = {hy + CW'(1), hx};
                node_addr = {hy + CW'(2), hx};
            end
            mbc_pkg::DIR_LEFT: begin
                wall_addr = {hy, hx - CW'(1)};
                node_addr = {hy, hx - CW'(2)};
            end
            default: begin
                wall_addr = {hy - CW'(1), hx};
                node_addr = {hy - CW'(2), hx};
            end
        endcase
    end

    always_comb begin
        map_we    = 1'b1;
        map_wd    = 1'b1;
        map_waddr = r_top;
        priority if (i_cmd.clr_step) begin
            map_waddr = r_clr_addr;
            map_wd    = 1'b0;
        end else if (i_cmd.head_wr) begin
            map_waddr = r_top;
        end else if (i_cmd.wall_wr) begin
            map_waddr = wall_addr;
        end else if (i_cmd.node_wr) begin
            map_waddr = node_addr;
        end else begin
            map_we = 1'b0;
        end
    end

    assign can_push  = (r_count < CNW'(STACK_DEPTH));
    assign stk_raddr = SAW'(r_count - CNW'(1));
    assign stk_we    = i_cmd.clr_step || (i_cmd.node_wr && can_push);
    assign stk_waddr = i_cmd.clr_step ? '0 : r_count[SAW-1:0];
    assign stk_wd    = i_cmd.clr_step ? '0 : node_addr;

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wd;
        end
        if (i_cmd.nbr_rd) begin
            r_map_q <= map_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wd;
        end
        if (i_cmd.rd_top) begin
            r_top <= stk_mem[stk_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_rv) begin
            r_rv <= i_random_value;
        end
        if (i_cmd.col_en) begin
            r_walled[i_cmd.col_idx] <= !r_map_q && inb[i_cmd.col_idx];
        end
        if (i_cmd.choose) begin
            r_dir <= mbc_pkg::pick_dir(r_walled, r_rv);
        end
        unique case (i_cmd.emit)
            mbc_pkg::EMIT_FIN: begin
                r_x <= 7'd0; r_y <= 7'd0; r_odir <= mbc_pkg::DIR_NONE; r_fin <= 1'b1;
            end
            mbc_pkg::EMIT_ZERO: begin
                r_x <= 7'd0; r_y <= 7'd0; r_odir <= mbc_pkg::DIR_NONE; r_fin <= 1'b0;
            end
            mbc_pkg::EMIT_POP: begin
                r_x <= to7(hx); r_y <= to7(hy); r_odir <= mbc_pkg::DIR_NONE; r_fin <= 1'b0;
            end
            mbc_pkg::EMIT_STEP: begin
                r_x <= to7(hx); r_y <= to7(hy); r_odir <= r_dir; r_fin <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw       <= 8'd100;
            r_gh       <= 8'd100;
            r_count    <= CNW'(1);
            r_clr_addr <= '0;
            r_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    mbc_pkg::CFG_GRID_WIDTH:  r_gw <= i_cfg_data;
                    default:                  r_gh <= i_cfg_data;
                endcase
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + MW'(1);
                r_count    <= CNW'(1);
            end else if (i_cmd.pop) begin
                r_count <= r_count - CNW'(1);
            end else if (i_cmd.node_wr && can_push) begin
                r_count <= r_count + CNW'(1);
            end
            r_valid <= (i_cmd.emit != mbc_pkg::EMIT_NONE);
        end
    end

    assign o_stat.empty    = (r_count == '0);
    assign o_stat.clr_last = &r_clr_addr;
    assign o_stat.none     = (r_walled == 4'd0);

    assign o_valid     = r_valid;
    assign o_node_x    = r_x;
    assign o_node_y    = r_y;
    assign o_direction = r_odir;
    assign o_finished  = r_fin;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNW'(STACK_DEPTH))
        else $error("stack count past depth");

    a_fin_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_fin) |-> (r_odir == mbc_pkg::DIR_NONE && r_x == 7'd0 && r_y == 7'd0))
        else $error("finished word carries a node");

    a_carve_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wall_wr || i_cmd.node_wr) |-> (r_dir != mbc_pkg::DIR_NONE))
        else $error("carve without a chosen direction");
`endif

endmodule
